// ----- rtl/core/pmu_command_framer_unit_defines.svh -----
// assertion macros shared by the framer checker
// no dependencies
`ifndef PMU_COMMAND_FRAMER_UNIT_DEFINES_SVH
`define PMU_COMMAND_FRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define PMU_CF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PMU_CF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/pmu_cf_pkg.sv -----
// types, codes and command tables of the power-manager command framer
// no dependencies
`default_nettype none

package pmu_cf_pkg;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_DATA  = 2'd1;
   localparam logic [1:0] CMD_RECV  = 2'd2;

   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned SLOT_WIDTH  = $clog2(MAX_RESULTS);

   typedef enum logic [2:0] {
      KIND_TX    = 3'd0,
      KIND_REQ   = 3'd1,
      KIND_REPLY = 3'd2,
      KIND_DONE  = 3'd3,
      KIND_ERR   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_SEND = 2'd1,
      PH_RECV = 2'd2
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic [7:0] reply_index;
      logic [8:0] reply_length;
   } result_type;

   // all results caused by one request beat
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] slot;
      logic [SLOT_WIDTH-1:0]        last_slot;
   } frame_type;

   function automatic result_type make_result(input kind_type k, input logic [7:0] b,
                                              input logic [7:0] idx, input logic [8:0] len);
      result_type r;
      r.kind         = k;
      r.out_byte     = b;
      r.reply_index  = idx;
      r.reply_length = len;
      return r;
   endfunction

   // send table: a length byte follows the command byte
   function automatic logic send_has_length(input logic [7:0] code);
      logic has_len;
      unique case (code) inside
         [16:17], [24:25], 31, [33:36], 40, [48:49], 51, [56:59], [64:65],
         [72:73], 76, [80:83], [85:87], [88:92], 96, [104:109], [112:114],
         [120:121], [126:127], 128, 130, 136, [144:145], [152:153],
         [160:163], 165, [168:171], 208, [216:217], [220:221], [225:226],
         232, 234, 236, 239: has_len = 1'b0;
         default: has_len = 1'b1;
      endcase
      return has_len;
   endfunction

   // receive table: 0 none, 1 single byte, >1 fixed count, negative length first
   function automatic logic signed [7:0] recv_entry(input logic [7:0] code);
      logic signed [7:0] r;
      unique case (code) inside
         [0:7], [16:23], 31, [32:39], [48:55], [64:71], [80:87], 89,
         [96:103], [112:119], [128:135], [144:151], [160:167], [169:171],
         [176:183], [192:199], [208:215], [224:225], [227:231], 239,
         [240:247]: r = 8'sd0;
         126, 127, 226: r = 8'sd1;
         24, 25, 59, 72, 73, 88, 152, 153, 168, 216, 217, 220, 234: r = 8'sd2;
         90, 91, 106: r = 8'sd3;
         104, 105: r = 8'sd4;
         56: r = 8'sd5;
         136: r = 8'sd6;
         107: r = 8'sd9;
         57: r = 8'sd21;
         default: r = -8'sd1;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pmu_cf_if.sv -----
// request and response channel interfaces of the framer
// no dependencies
`default_nettype none

interface pmu_cf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] code;
   logic [7:0] length;
   logic [7:0] byte_value;

   modport source (output valid, cmd, code, length, byte_value, input ready);
   modport sink (input valid, cmd, code, length, byte_value, output ready);
endinterface

interface pmu_cf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] out_byte;
   logic [7:0] reply_index;
   logic [8:0] reply_length;
   logic       last;

   modport source (output valid, kind, out_byte, reply_index, reply_length, last,
                   input ready);
   modport sink (input valid, kind, out_byte, reply_index, reply_length, last,
                 output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pmu_cf_fifo.sv -----
// frame queue between the framer front and back
// depends on pmu_cf_pkg
`default_nettype none

module pmu_cf_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pmu_cf_pkg::frame_type push_data,
   output logic                  full,
   input  logic                  pop,
   output pmu_cf_pkg::frame_type head,
   output logic                  empty
);
   import pmu_cf_pkg::*;

   localparam int unsigned PtrWidth   = $clog2(DEPTH);
   localparam int unsigned CountWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

   frame_type             store_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == FullCount);
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/pmu_cf_front.sv -----
// framer front: accepts request beats, tracks the exchange phase and
// builds the frame of results for each beat; depends on pmu_cf_pkg, pmu_cf_if
`default_nettype none

module pmu_cf_front (
   input  logic                  clock,
   input  logic                  reset,
   pmu_cf_req_if.sink            req_ch,
   input  logic                  queue_full,
   output logic                  push,
   output pmu_cf_pkg::frame_type frame
);
   import pmu_cf_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [7:0]        code_ff, code_in;
   logic [7:0]        send_rem_ff, send_rem_in;
   logic [7:0]        reply_rem_ff, reply_rem_in;
   logic [7:0]        reply_pos_ff, reply_pos_in;
   logic [8:0]        reply_total_ff, reply_total_in;
   logic              await_ff, await_in;
   logic [2:0]        n_res;
   logic              start_reply;
   logic signed [7:0] recv_r;

   assign req_ch.ready = ~queue_full;
   assign push         = req_ch.valid & req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         code_ff        <= '0;
         send_rem_ff    <= '0;
         reply_rem_ff   <= '0;
         reply_pos_ff   <= '0;
         reply_total_ff <= '0;
         await_ff       <= 1'b0;
      end else if (push) begin
         phase_ff       <= phase_in;
         code_ff        <= code_in;
         send_rem_ff    <= send_rem_in;
         reply_rem_ff   <= reply_rem_in;
         reply_pos_ff   <= reply_pos_in;
         reply_total_ff <= reply_total_in;
         await_ff       <= await_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      code_in        = code_ff;
      send_rem_in    = send_rem_ff;
      reply_rem_in   = reply_rem_ff;
      reply_pos_in   = reply_pos_ff;
      reply_total_in = reply_total_ff;
      await_in       = await_ff;
      frame          = '0;
      n_res          = '0;
      start_reply    = 1'b0;
      recv_r         = '0;

      if (req_ch.cmd == CMD_START && phase_ff == PH_IDLE) begin
         code_in = req_ch.code;
         frame.slot[n_res[SLOT_WIDTH-1:0]] = make_result(KIND_TX, req_ch.code, 8'd0, 9'd0);
         n_res = n_res + 3'd1;
         if (send_has_length(req_ch.code)) begin
            frame.slot[n_res[SLOT_WIDTH-1:0]] =
               make_result(KIND_TX, req_ch.length, 8'd0, 9'd0);
            n_res = n_res + 3'd1;
         end
         if (req_ch.length == 8'd0) begin
            start_reply = 1'b1;
         end else begin
            send_rem_in = req_ch.length;
            phase_in    = PH_SEND;
         end
      end else if (req_ch.cmd == CMD_DATA && phase_ff == PH_SEND) begin
         frame.slot[n_res[SLOT_WIDTH-1:0]] =
            make_result(KIND_TX, req_ch.byte_value, 8'd0, 9'd0);
         n_res = n_res + 3'd1;
         send_rem_in = send_rem_ff - 8'd1;
         if (send_rem_in == 8'd0) begin
            start_reply = 1'b1;
         end
      end else if (req_ch.cmd == CMD_RECV && phase_ff == PH_RECV) begin
         if (await_ff) begin
            // partner's length byte
            await_in       = 1'b0;
            reply_total_in = {1'b0, req_ch.byte_value} + 9'd1;
            reply_rem_in   = req_ch.byte_value;
            reply_pos_in   = 8'd1;
            if (req_ch.byte_value == 8'd0) begin
               frame.slot[n_res[SLOT_WIDTH-1:0]] =
                  make_result(KIND_DONE, 8'd0, 8'd0, reply_total_in);
               phase_in = PH_IDLE;
            end else begin
               frame.slot[n_res[SLOT_WIDTH-1:0]] = make_result(KIND_REQ, 8'd0, 8'd0, 9'd0);
            end
            n_res = n_res + 3'd1;
         end else begin
            frame.slot[n_res[SLOT_WIDTH-1:0]] =
               make_result(KIND_REPLY, req_ch.byte_value, reply_pos_ff, 9'd0);
            n_res = n_res + 3'd1;
            reply_pos_in = reply_pos_ff + 8'd1;
            if (reply_rem_ff != 8'd0) begin
               reply_rem_in = reply_rem_ff - 8'd1;
            end
            if (reply_rem_in == 8'd0) begin
               frame.slot[n_res[SLOT_WIDTH-1:0]] =
                  make_result(KIND_DONE, 8'd0, 8'd0, reply_total_ff);
               phase_in = PH_IDLE;
            end else begin
               frame.slot[n_res[SLOT_WIDTH-1:0]] = make_result(KIND_REQ, 8'd0, 8'd0, 9'd0);
            end
            n_res = n_res + 3'd1;
         end
      end else begin
         frame.slot[n_res[SLOT_WIDTH-1:0]] = make_result(KIND_ERR, 8'd0, 8'd0, 9'd0);
         n_res = n_res + 3'd1;
      end

      if (start_reply) begin
         recv_r = recv_entry(code_in);
         if (recv_r == 8'sd0) begin
            frame.slot[n_res[SLOT_WIDTH-1:0]] = make_result(KIND_DONE, 8'd0, 8'd0, 9'd0);
            n_res    = n_res + 3'd1;
            phase_in = PH_IDLE;
         end else begin
            phase_in = PH_RECV;
            await_in = 1'b0;
            if (recv_r == 8'sd1) begin
               reply_pos_in   = 8'd0;
               reply_rem_in   = 8'd1;
               reply_total_in = 9'd1;
            end else begin
               // command echo at reply index 0
               frame.slot[n_res[SLOT_WIDTH-1:0]] =
                  make_result(KIND_REPLY, code_in, 8'd0, 9'd0);
               n_res        = n_res + 3'd1;
               reply_pos_in = 8'd1;
               if (recv_r[7]) begin
                  await_in       = 1'b1;
                  reply_rem_in   = 8'd0;
                  reply_total_in = 9'd0;
               end else begin
                  reply_rem_in   = $unsigned(recv_r) - 8'd1;
                  reply_total_in = {1'b0, $unsigned(recv_r)};
               end
            end
            frame.slot[n_res[SLOT_WIDTH-1:0]] = make_result(KIND_REQ, 8'd0, 8'd0, 9'd0);
            n_res = n_res + 3'd1;
         end
      end

      frame.last_slot = SLOT_WIDTH'(n_res - 3'd1);
   end

endmodule

`default_nettype wire

// ----- rtl/core/pmu_cf_back.sv -----
// framer back: unpacks queued frames into response beats, one per cycle while
// rsp_ch.ready is high, through an output register; depends on pmu_cf_pkg, pmu_cf_if
`default_nettype none

module pmu_cf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  pmu_cf_pkg::frame_type head,
   input  logic                  empty,
   output logic                  pop,
   pmu_cf_rsp_if.source          rsp_ch
);
   import pmu_cf_pkg::*;

   logic [SLOT_WIDTH-1:0] slot_ff, slot_in;
   logic                  valid_ff, valid_in;
   result_type            out_ff, out_in;
   logic                  last_ff, last_in;
   logic                  load;

   assign load = ~empty & (~valid_ff | rsp_ch.ready);

   always_comb begin
      valid_in = valid_ff & ~rsp_ch.ready;
      out_in   = out_ff;
      last_in  = last_ff;
      slot_in  = slot_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         out_in   = head.slot[slot_ff];
         last_in  = (slot_ff == head.last_slot);
         if (slot_ff == head.last_slot) begin
            pop     = 1'b1;
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.kind         = out_ff.kind;
   assign rsp_ch.out_byte     = out_ff.out_byte;
   assign rsp_ch.reply_index  = out_ff.reply_index;
   assign rsp_ch.reply_length = out_ff.reply_length;
   assign rsp_ch.last         = last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/pmu_command_framer_unit.sv -----
// top level of the power-manager command framer
// depends on pmu_cf_pkg, pmu_cf_if, pmu_cf_front, pmu_cf_fifo, pmu_cf_back
//
//   channel   direction  carries
//   req_ch    in         cmd, code, length, byte_value
//   rsp_ch    out        kind, out_byte, reply_index, reply_length, last
//
// one request beat can be taken every cycle while the frame queue has room
// each request beat yields one to four response beats, sent one per cycle while
// rsp_ch.ready is high, via the frame queue and the back end's output register
// a stalled response side fills the QUEUE_DEPTH-frame queue, then req_ch.ready drops
// reset is synchronous and clears phase, queue and output valid; no clearing pass
`default_nettype none

module pmu_command_framer_unit #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   pmu_cf_req_if.sink    req_ch,
   pmu_cf_rsp_if.source  rsp_ch
);
   import pmu_cf_pkg::*;

   frame_type push_frame;
   frame_type head_frame;
   logic      push;
   logic      pop;
   logic      queue_full;
   logic      queue_empty;

   pmu_cf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .frame      (push_frame)
   );

   pmu_cf_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_frame),
      .full      (queue_full),
      .pop       (pop),
      .head      (head_frame),
      .empty     (queue_empty)
   );

   pmu_cf_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head_frame),
      .empty  (queue_empty),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- rtl/core/pmu_cf_checker.sv -----
// port-level checks on the framer response channel, bound to the top level
// depends on pmu_cf_pkg and pmu_command_framer_unit_defines.svh
`default_nettype none
`include "pmu_command_framer_unit_defines.svh"

module pmu_cf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic [7:0] rsp_reply_index,
   input logic [8:0] rsp_reply_length,
   input logic       rsp_last
);
   import pmu_cf_pkg::*;

   `PMU_CF_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte) && $stable(rsp_reply_index) && $stable(rsp_reply_length) && $stable(rsp_last), "response beat changed while stalled")
   `PMU_CF_ASSERT_SAME(a_end_is_last, clock, reset, rsp_valid && (rsp_kind == KIND_DONE || rsp_kind == KIND_ERR), rsp_last, "done or error beat without last")
   `PMU_CF_ASSERT_SAME(a_index_only_reply, clock, reset, rsp_valid && rsp_kind != KIND_REPLY, rsp_reply_index == 8'd0, "reply index on a non-reply beat")
   `PMU_CF_ASSERT_SAME(a_length_only_done, clock, reset, rsp_valid && rsp_kind != KIND_DONE, rsp_reply_length == 9'd0, "reply length on a non-done beat")
   `PMU_CF_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "response valid right after reset")

endmodule

bind pmu_command_framer_unit pmu_cf_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_kind         (rsp_ch.kind),
   .rsp_out_byte     (rsp_ch.out_byte),
   .rsp_reply_index  (rsp_ch.reply_index),
   .rsp_reply_length (rsp_ch.reply_length),
   .rsp_last         (rsp_ch.last)
);

`default_nettype wire
